@@ rtl/core/pls_pkg.sv @@
package pls_pkg;

    // Field widths of the byte and result channels and of the scan counters.
    localparam int TEXT_W  = 8;
    localparam int WORD_W  = 64;
    localparam int LINE_W  = 16;
    localparam int LEN_W   = 12;
    localparam int POS_W   = 8;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Record layout.
    localparam int DIGEST_HEX_DIGITS = 64;
    localparam int DIGEST_W          = DIGEST_HEX_DIGITS * 4;
    localparam int DIG_IDX_W         = $clog2(DIGEST_HEX_DIGITS);
    localparam int PREFIX_LEN        = 11;
    localparam int PREFIX_IDX_W      = $clog2(PREFIX_LEN);
    localparam int MID_COLON_POS     = PREFIX_LEN + DIGEST_HEX_DIGITS;
    localparam int SECOND_START      = MID_COLON_POS + 1;
    localparam int RECORD_LEN        = SECOND_START + DIGEST_HEX_DIGITS;

    // Saturation limits of the counters.
    localparam logic [POS_W-1:0]  POS_MAX  = '1;
    localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // Register indexes on the configuration port.
    localparam logic REG_SPLIT_LINES  = 1'b0;
    localparam logic REG_MAX_LINE_LEN = 1'b1;

    // Register reset values.
    localparam logic             SPLIT_LINES_RESET  = 1'b1;
    localparam logic [LEN_W-1:0] MAX_LINE_LEN_RESET = LEN_W'(256);

    // Character codes.
    localparam logic [TEXT_W-1:0] CH_NUL   = 8'h00;
    localparam logic [TEXT_W-1:0] CH_TAB   = 8'h09;
    localparam logic [TEXT_W-1:0] CH_LF    = 8'h0a;
    localparam logic [TEXT_W-1:0] CH_VT    = 8'h0b;
    localparam logic [TEXT_W-1:0] CH_FF    = 8'h0c;
    localparam logic [TEXT_W-1:0] CH_CR    = 8'h0d;
    localparam logic [TEXT_W-1:0] CH_SP    = 8'h20;
    localparam logic [TEXT_W-1:0] CH_COLON = 8'h3a;
    localparam logic [TEXT_W-1:0] CH_0     = 8'h30;
    localparam logic [TEXT_W-1:0] CH_9     = 8'h39;
    localparam logic [TEXT_W-1:0] CH_A     = 8'h61;
    localparam logic [TEXT_W-1:0] CH_F     = 8'h66;

    // Configuration seen by the scanner.
    typedef struct packed {
        logic             split_lines;
        logic [LEN_W-1:0] max_line_len;
    } cfg_t;

    // Decoded hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // Expected character at each place of the record prefix.
    function automatic logic [TEXT_W-1:0] prefix_char(input logic [PREFIX_IDX_W-1:0] idx);
        logic [TEXT_W-1:0] ch;
        case (idx)
            4'd0:    ch = 8'h7a;
            4'd1:    ch = 8'h32;
            4'd2:    ch = 8'h33;
            4'd3:    ch = 8'h2d;
            4'd4:    ch = 8'h70;
            4'd5:    ch = 8'h69;
            4'd6:    ch = 8'h6e;
            4'd7:    ch = 8'h2d;
            4'd8:    ch = 8'h76;
            4'd9:    ch = 8'h31;
            4'd10:   ch = CH_COLON;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // ASCII whitespace.
    function automatic logic is_space(input logic [TEXT_W-1:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF);
    endfunction

    // Lowercase hex digit decode.
    function automatic hex_t hex_decode(input logic [TEXT_W-1:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_0);
        end
        else if (c >= CH_A && c <= CH_F)
        begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_A + 8'd10);
        end
        return h;
    endfunction

endpackage

@@ rtl/core/pls_text_if.sv @@
interface pls_text_if;
    logic                          valid;
    logic                          ready;
    logic [pls_pkg::TEXT_W-1:0]    text_byte;
    logic                          text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

@@ rtl/core/pls_result_if.sv @@
interface pls_result_if;
    logic                          valid;
    logic                          ready;
    logic                          pin_found;
    logic [pls_pkg::LINE_W-1:0]    found_line;
    logic [pls_pkg::WORD_W-1:0]    manifest_word0;
    logic [pls_pkg::WORD_W-1:0]    manifest_word1;
    logic [pls_pkg::WORD_W-1:0]    manifest_word2;
    logic [pls_pkg::WORD_W-1:0]    manifest_word3;
    logic [pls_pkg::WORD_W-1:0]    installer_word0;
    logic [pls_pkg::WORD_W-1:0]    installer_word1;
    logic [pls_pkg::WORD_W-1:0]    installer_word2;
    logic [pls_pkg::WORD_W-1:0]    installer_word3;

    modport source (
        output valid, output pin_found, output found_line,
        output manifest_word0, output manifest_word1, output manifest_word2,
        output manifest_word3, output installer_word0, output installer_word1,
        output installer_word2, output installer_word3, input ready
    );
    modport sink (
        input valid, input pin_found, input found_line,
        input manifest_word0, input manifest_word1, input manifest_word2,
        input manifest_word3, input installer_word0, input installer_word1,
        input installer_word2, input installer_word3, output ready
    );
endinterface

@@ rtl/core/pls_apb_regs.sv @@
module pls_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pls_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pls_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pls_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output pls_pkg::cfg_t                  cfg
);
    import pls_pkg::*;

    logic             split_lines_reg;
    logic [LEN_W-1:0] max_line_len_reg;
    logic             wr_en;
    logic             reg_idx;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_lines_reg  <= SPLIT_LINES_RESET;
            max_line_len_reg <= MAX_LINE_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SPLIT_LINES:  split_lines_reg  <= pwdata[0];
                REG_MAX_LINE_LEN: max_line_len_reg <= pwdata[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read data is returned from the addressed register.
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_SPLIT_LINES:  prdata[0]         = split_lines_reg;
            REG_MAX_LINE_LEN: prdata[LEN_W-1:0] = max_line_len_reg;
            default:          prdata            = '0;
        endcase
    end

    assign cfg.split_lines  = split_lines_reg;
    assign cfg.max_line_len = max_line_len_reg;

endmodule

@@ rtl/core/pin_record_line_scanner.sv @@
// Pin record line scanner.
//
// Bytes of a text arrive on text_in, one transfer per byte, text_last set
// on the final byte. Every byte that ends the text produces exactly one
// transfer on result_out: the first valid record of the text as two
// 256-bit digests (four 64-bit words each, most significant first), its
// zero-based line number and the pin_found flag. Other bytes produce none.
// Registers split_lines and max_line_len sit on the APB port at byte addresses 0 and 4.
// The user must see they are written only while the block is idle; nothing enforces it.
//
// Throughput is one byte per cycle while the result register can take a
// result; a final byte waits while it is full and not taken. A byte is
// held in the input register while the scan state is updated; the result
// of a final byte is loaded from there into the output register, which
// drives result_out.
// Reset clears the scan state and loads the register defaults. When the
// receiver stalls, the pending result is held and the block keeps taking
// bytes until a second final byte is waiting in the input register.
module pin_record_line_scanner (
    input  logic                           clk,
    input  logic                           rst_n,
    pls_text_if.sink                       text_in,
    pls_result_if.source                   result_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pls_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pls_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pls_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import pls_pkg::*;

    cfg_t cfg;

    // Input register.
    logic              s1_valid_reg, s1_valid_next;
    logic [TEXT_W-1:0] s1_byte_reg;
    logic              s1_last_reg;

    // Scan state.
    logic [POS_W-1:0]    record_pos_reg, record_pos_next;
    logic [LEN_W-1:0]    raw_len_reg, raw_len_next;
    logic                started_reg, started_next;
    logic                trail_reg, trail_next;
    logic                bad_reg, bad_next;
    logic                all_zero_reg, all_zero_next;
    logic                text_ended_reg, text_ended_next;
    logic                found_reg, found_next;
    logic [LINE_W-1:0]   line_cnt_reg, line_cnt_next;
    logic [DIGEST_W-1:0] work_m_reg, work_m_next;
    logic [DIGEST_W-1:0] work_i_reg, work_i_next;
    logic [DIGEST_W-1:0] kept_m_reg, kept_m_next;
    logic [DIGEST_W-1:0] kept_i_reg, kept_i_next;
    logic [LINE_W-1:0]   kept_line_reg, kept_line_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [LINE_W-1:0]   out_line_reg, out_line_next;
    logic [DIGEST_W-1:0] out_m_reg, out_m_next;
    logic [DIGEST_W-1:0] out_i_reg, out_i_next;

    // Per-byte scan signals.
    logic                out_free;
    logic                s1_fire;
    logic                active;
    logic                is_nul;
    logic                is_lf;
    logic                close_now;
    logic                close_ok;
    logic                new_find;
    hex_t                hex;
    logic [POS_W-1:0]    dig_off;
    logic [DIG_IDX_W-1:0] dig_idx;
    logic [POS_W-1:0]    nib_base;
    logic [POS_W-1:0]    r_pos;
    logic [LEN_W-1:0]    r_raw;
    logic                r_started;
    logic                r_trail;
    logic                r_bad;
    logic                r_zero;
    logic [DIGEST_W-1:0] r_wm;
    logic [DIGEST_W-1:0] r_wi;
    logic [LINE_W-1:0]   find_line;

    pls_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: a final byte waits only while the result register is full and not taken.
    assign out_free      = !out_valid_reg || result_out.ready;
    assign s1_fire       = s1_valid_reg && (!s1_last_reg || out_free);
    assign text_in.ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        if (text_in.valid && text_in.ready)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // Byte classification.
    assign active  = !text_ended_reg && !found_reg;
    assign is_nul  = (s1_byte_reg == CH_NUL);
    assign is_lf   = cfg.split_lines && (s1_byte_reg == CH_LF);
    assign hex     = hex_decode(s1_byte_reg);
    assign dig_off = (record_pos_reg < POS_W'(MID_COLON_POS)) ?
                     record_pos_reg - POS_W'(PREFIX_LEN) :
                     record_pos_reg - POS_W'(SECOND_START);
    assign dig_idx  = dig_off[DIG_IDX_W-1:0];
    assign nib_base = {DIG_IDX_W'(DIGEST_HEX_DIGITS - 1) - dig_idx, 2'b00};

    // Record state after this byte is taken in.
    always_comb
    begin
        r_pos     = record_pos_reg;
        r_raw     = raw_len_reg;
        r_started = started_reg;
        r_trail   = trail_reg;
        r_bad     = bad_reg;
        r_zero    = all_zero_reg;
        r_wm      = work_m_reg;
        r_wi      = work_i_reg;
        if (active && !is_nul && !is_lf)
        begin
            if (raw_len_reg != LEN_MAX)
                r_raw = raw_len_reg + 1'b1;
            if (is_space(s1_byte_reg))
            begin
                if (started_reg)
                    r_trail = 1'b1;
            end
            else
            begin
                r_started = 1'b1;
                if (trail_reg)
                    r_bad = 1'b1;
                else if (record_pos_reg < POS_W'(PREFIX_LEN))
                begin
                    if (s1_byte_reg != prefix_char(record_pos_reg[PREFIX_IDX_W-1:0]))
                        r_bad = 1'b1;
                end
                else if (record_pos_reg < POS_W'(MID_COLON_POS) ||
                         (record_pos_reg > POS_W'(MID_COLON_POS) &&
                          record_pos_reg < POS_W'(RECORD_LEN)))
                begin
                    if (!hex.ok)
                        r_bad = 1'b1;
                    else
                    begin
                        if (hex.val != 4'd0)
                            r_zero = 1'b0;
                        if (record_pos_reg < POS_W'(MID_COLON_POS))
                            r_wm[nib_base +: 4] = hex.val;
                        else
                            r_wi[nib_base +: 4] = hex.val;
                    end
                end
                else if (record_pos_reg == POS_W'(MID_COLON_POS))
                begin
                    if (s1_byte_reg != CH_COLON)
                        r_bad = 1'b1;
                end
                else
                    r_bad = 1'b1;
                if (record_pos_reg != POS_MAX)
                    r_pos = record_pos_reg + 1'b1;
            end
        end
    end

    // Record close and acceptance check.
    assign close_now = active && (is_nul || is_lf || s1_last_reg);
    assign close_ok  = !r_bad && (r_pos == POS_W'(RECORD_LEN)) && !r_zero &&
                       (LEN_W'(RECORD_LEN) < cfg.max_line_len) &&
                       (!cfg.split_lines || (r_raw < cfg.max_line_len));
    assign new_find  = close_now && close_ok;
    assign find_line = cfg.split_lines ? line_cnt_reg : '0;

    // Next scan state and result.
    always_comb
    begin
        record_pos_next = record_pos_reg;
        raw_len_next    = raw_len_reg;
        started_next    = started_reg;
        trail_next      = trail_reg;
        bad_next        = bad_reg;
        all_zero_next   = all_zero_reg;
        text_ended_next = text_ended_reg;
        found_next      = found_reg;
        line_cnt_next   = line_cnt_reg;
        work_m_next     = work_m_reg;
        work_i_next     = work_i_reg;
        kept_m_next     = kept_m_reg;
        kept_i_next     = kept_i_reg;
        kept_line_next  = kept_line_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        out_found_next  = out_found_reg;
        out_line_next   = out_line_reg;
        out_m_next      = out_m_reg;
        out_i_next      = out_i_reg;

        if (s1_fire)
        begin
            work_m_next = r_wm;
            work_i_next = r_wi;
            if (close_now || s1_last_reg)
            begin
                record_pos_next = '0;
                raw_len_next    = '0;
                started_next    = 1'b0;
                trail_next      = 1'b0;
                bad_next        = 1'b0;
                all_zero_next   = 1'b1;
            end
            else
            begin
                record_pos_next = r_pos;
                raw_len_next    = r_raw;
                started_next    = r_started;
                trail_next      = r_trail;
                bad_next        = r_bad;
                all_zero_next   = r_zero;
            end

            if (s1_last_reg)
            begin
                // Report and start a fresh text.
                out_valid_next  = 1'b1;
                out_found_next  = found_reg || new_find;
                if (found_reg)
                begin
                    out_line_next = kept_line_reg;
                    out_m_next    = kept_m_reg;
                    out_i_next    = kept_i_reg;
                end
                else if (new_find)
                begin
                    out_line_next = find_line;
                    out_m_next    = r_wm;
                    out_i_next    = r_wi;
                end
                else
                begin
                    out_line_next = '0;
                    out_m_next    = '0;
                    out_i_next    = '0;
                end
                text_ended_next = 1'b0;
                found_next      = 1'b0;
                line_cnt_next   = '0;
            end
            else
            begin
                if (active && is_nul)
                    text_ended_next = 1'b1;
                if (active && is_lf && line_cnt_reg != LINE_MAX)
                    line_cnt_next = line_cnt_reg + 1'b1;
                if (new_find)
                begin
                    found_next     = 1'b1;
                    kept_line_next = find_line;
                    kept_m_next    = r_wm;
                    kept_i_next    = r_wi;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            record_pos_reg <= '0;
            raw_len_reg    <= '0;
            started_reg    <= 1'b0;
            trail_reg      <= 1'b0;
            bad_reg        <= 1'b0;
            all_zero_reg   <= 1'b1;
            text_ended_reg <= 1'b0;
            found_reg      <= 1'b0;
            line_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            record_pos_reg <= record_pos_next;
            raw_len_reg    <= raw_len_next;
            started_reg    <= started_next;
            trail_reg      <= trail_next;
            bad_reg        <= bad_next;
            all_zero_reg   <= all_zero_next;
            text_ended_reg <= text_ended_next;
            found_reg      <= found_next;
            line_cnt_reg   <= line_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            s1_byte_reg <= text_in.text_byte;
            s1_last_reg <= text_in.text_last;
        end
        work_m_reg    <= work_m_next;
        work_i_reg    <= work_i_next;
        kept_m_reg    <= kept_m_next;
        kept_i_reg    <= kept_i_next;
        kept_line_reg <= kept_line_next;
        out_found_reg <= out_found_next;
        out_line_reg  <= out_line_next;
        out_m_reg     <= out_m_next;
        out_i_reg     <= out_i_next;
    end

    // Result channel.
    assign result_out.valid           = out_valid_reg;
    assign result_out.pin_found       = out_found_reg;
    assign result_out.found_line      = out_line_reg;
    assign result_out.manifest_word0  = out_m_reg[4*WORD_W-1:3*WORD_W];
    assign result_out.manifest_word1  = out_m_reg[3*WORD_W-1:2*WORD_W];
    assign result_out.manifest_word2  = out_m_reg[2*WORD_W-1:WORD_W];
    assign result_out.manifest_word3  = out_m_reg[WORD_W-1:0];
    assign result_out.installer_word0 = out_i_reg[4*WORD_W-1:3*WORD_W];
    assign result_out.installer_word1 = out_i_reg[3*WORD_W-1:2*WORD_W];
    assign result_out.installer_word2 = out_i_reg[2*WORD_W-1:WORD_W];
    assign result_out.installer_word3 = out_i_reg[WORD_W-1:0];

endmodule

@@ rtl/core/pls_checker.sv @@
module pls_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       pin_found,
    input logic [pls_pkg::LINE_W-1:0] found_line,
    input logic [pls_pkg::WORD_W-1:0] m0,
    input logic [pls_pkg::WORD_W-1:0] m1,
    input logic [pls_pkg::WORD_W-1:0] m2,
    input logic [pls_pkg::WORD_W-1:0] m3,
    input logic [pls_pkg::WORD_W-1:0] i0,
    input logic [pls_pkg::WORD_W-1:0] i1,
    input logic [pls_pkg::WORD_W-1:0] i2,
    input logic [pls_pkg::WORD_W-1:0] i3
);
    import pls_pkg::*;

    // A stalled result transfer keeps its flag, line, manifest_word0 and installer_word3.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pin_found) &&
        $stable(found_line) && $stable(m0) && $stable(i3))
        else $error("result changed while stalled");

    // Bytes are refused only while a finished result is stuck.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // No record found means an all-zero result.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pin_found |-> found_line == '0 && m0 == '0 && m1 == '0 &&
        m2 == '0 && m3 == '0 && i0 == '0 && i1 == '0 && i2 == '0 && i3 == '0)
        else $error("result fields set without a found record");

    // The all-zero sentinel is never reported as found.
    a_no_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pin_found |-> (m0 | m1 | m2 | m3 | i0 | i1 | i2 | i3) != '0)
        else $error("sentinel record reported as found");

endmodule

bind pin_record_line_scanner pls_checker u_pls_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (text_in.ready),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .pin_found  (result_out.pin_found),
    .found_line (result_out.found_line),
    .m0         (result_out.manifest_word0),
    .m1         (result_out.manifest_word1),
    .m2         (result_out.manifest_word2),
    .m3         (result_out.manifest_word3),
    .i0         (result_out.installer_word0),
    .i1         (result_out.installer_word1),
    .i2         (result_out.installer_word2),
    .i3         (result_out.installer_word3)
);
